/* rtl/core/assert_macros.svh */
// Assertion macros used by the port-level checker of the matcher.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kmp_sm_pkg.sv */
// Package of the KMP stream matcher: request codes, status codes, state and
// control/status bundle types. No dependencies.
`default_nettype none

package kmp_sm_pkg;

    localparam int REQ_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int TEXT_POS_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_TEXT    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FAIL_READ,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        SEL_BUILD,
        SEL_MATCHED,
        SEL_PLEN_LAST,
        SEL_FAIL_DATA
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      issue;
        addr_sel_t sel;
        logic      finalize;
        logic      commit;
    } dp_cmd_t;

    typedef struct packed {
        req_t req;
        logic plen_zero;
        logic plen_full;
        logic resume_ge;
        logic fall_back;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/kmp_sm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module kmp_sm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/kmp_sm_ctrl.sv */
// Controller state machine of the KMP stream matcher: sequences each request
// through dispatch, failure-chain walk and commit. Uses kmp_sm_pkg.
`default_nettype none

module kmp_sm_ctrl
    import kmp_sm_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output      logic     s_ready,
    input  wire dp_stat_t stat,
    output      dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.sel      = SEL_BUILD;
        cmd.finalize = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (stat.req)
                    REQ_APPEND: begin
                        if (stat.plen_full) begin
                            state_next = ST_FINISH;
                        end else begin
                            cmd.issue  = 1'b1;
                            cmd.sel    = SEL_BUILD;
                            state_next = stat.plen_zero ? ST_FINISH : ST_SCAN;
                        end
                    end
                    REQ_TEXT: begin
                        if (stat.plen_zero) begin
                            state_next = ST_FINISH;
                        end else if (stat.resume_ge) begin
                            cmd.issue  = 1'b1;
                            cmd.sel    = SEL_PLEN_LAST;
                            state_next = ST_FAIL_READ;
                        end else begin
                            cmd.issue  = 1'b1;
                            cmd.sel    = SEL_MATCHED;
                            state_next = ST_SCAN;
                        end
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FAIL_READ: begin
                cmd.issue  = 1'b1;
                cmd.sel    = SEL_FAIL_DATA;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (stat.fall_back) begin
                    cmd.issue = 1'b1;
                    cmd.sel   = SEL_FAIL_DATA;
                end else begin
                    cmd.finalize = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/kmp_sm_datapath.sv */
// Datapath of the KMP stream matcher: pattern and failure-table RAMs, search
// state registers and the result register. Uses kmp_sm_pkg and kmp_sm_ram.
`default_nettype none

module kmp_sm_datapath
    import kmp_sm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int CW          = $clog2(MAX_PATTERN + 1),
    parameter int DATA_W      = ((4 + 2 * CW + TEXT_POS_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire dp_cmd_t           cmd,
    output      dp_stat_t          stat,
    input  wire logic              m_ready,
    output      logic              m_valid,
    output      logic [DATA_W-1:0] m_data
);

    localparam int AW = $clog2(MAX_PATTERN);

    req_t                  req_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic [CW-1:0]         k_reg;
    logic [CW-1:0]         k_next;
    logic [CW-1:0]         plen_reg;
    logic [CW-1:0]         plen_next;
    logic [CW-1:0]         build_reg;
    logic [CW-1:0]         build_next;
    logic [CW-1:0]         matched_reg;
    logic [CW-1:0]         matched_next;
    logic                  found_reg;
    logic                  found_next;
    logic [TEXT_POS_W-1:0] cnt_reg;
    logic [TEXT_POS_W-1:0] cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    status_t               out_status_reg;
    logic                  out_hit_reg;
    logic                  out_found_reg;
    logic [CW-1:0]         out_matched_reg;
    logic [CW-1:0]         out_plen_reg;
    logic [TEXT_POS_W-1:0] out_cnt_reg;

    status_t               status_c;
    logic                  hit_c;
    logic [CW-1:0]         addr;
    logic [CW-1:0]         addr_minus;
    logic [AW-1:0]         fail_raddr;
    logic [BYTE_W-1:0]     pat_rdata;
    logic [CW-1:0]         fail_rdata;
    logic                  wr_en;
    logic                  byte_eq;

    always_comb begin
        case (cmd.sel)
            SEL_BUILD:     addr = build_reg;
            SEL_MATCHED:   addr = matched_reg;
            SEL_PLEN_LAST: addr = plen_reg - CW'(1);
            SEL_FAIL_DATA: addr = fail_rdata;
            default:       addr = build_reg;
        endcase
    end

    assign addr_minus = addr - CW'(1);
    assign fail_raddr = (cmd.sel == SEL_PLEN_LAST) ? addr[AW-1:0] : addr_minus[AW-1:0];
    assign byte_eq    = (pat_rdata == byte_reg);
    assign wr_en      = cmd.commit && (req_reg == REQ_APPEND) && !stat.plen_full;

    kmp_sm_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(MAX_PATTERN)
    ) u_pattern_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(plen_reg[AW-1:0]),
        .wdata(byte_reg),
        .re   (cmd.issue),
        .raddr(addr[AW-1:0]),
        .rdata(pat_rdata)
    );

    kmp_sm_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_PATTERN)
    ) u_failure_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(plen_reg[AW-1:0]),
        .wdata(k_reg),
        .re   (cmd.issue),
        .raddr(fail_raddr),
        .rdata(fail_rdata)
    );

    assign stat.req       = req_reg;
    assign stat.plen_zero = (plen_reg == '0);
    assign stat.plen_full = (plen_reg == CW'(MAX_PATTERN));
    assign stat.resume_ge = (matched_reg >= plen_reg);
    assign stat.fall_back = (k_reg != '0) && !byte_eq;
    assign stat.out_free  = !out_valid_reg || m_ready;

    always_comb begin
        k_next = k_reg;
        if (cmd.issue) begin
            k_next = addr;
        end else if (cmd.finalize) begin
            k_next = k_reg + CW'(byte_eq);
        end
    end

    always_comb begin
        plen_next    = plen_reg;
        build_next   = build_reg;
        matched_next = matched_reg;
        found_next   = found_reg;
        cnt_next     = cnt_reg;
        status_c     = STAT_OK;
        hit_c        = 1'b0;
        if (cmd.commit) begin
            case (req_reg)
                REQ_CLEAR: begin
                    plen_next    = '0;
                    build_next   = '0;
                    matched_next = '0;
                    found_next   = 1'b0;
                    cnt_next     = '0;
                end
                REQ_APPEND: begin
                    if (stat.plen_full) begin
                        status_c = STAT_FULL;
                    end else begin
                        build_next = k_reg;
                        plen_next  = plen_reg + CW'(1);
                    end
                end
                REQ_RESTART: begin
                    matched_next = '0;
                    found_next   = 1'b0;
                    cnt_next     = '0;
                end
                REQ_TEXT: begin
                    cnt_next = cnt_reg + TEXT_POS_W'(1);
                    if (stat.plen_zero) begin
                        matched_next = '0;
                        status_c     = STAT_EMPTY;
                    end else begin
                        matched_next = k_reg;
                        if (k_reg == plen_reg) begin
                            hit_c      = 1'b1;
                            found_next = 1'b1;
                        end
                    end
                end
                default: begin
                    status_c = STAT_OK;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg      <= '0;
            build_reg     <= '0;
            matched_reg   <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            plen_reg      <= plen_next;
            build_reg     <= build_next;
            matched_reg   <= matched_next;
            found_reg     <= found_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        if (cmd.capture) begin
            req_reg  <= req_t'(req_type);
            byte_reg <= data_byte;
        end
        if (cmd.commit) begin
            out_status_reg  <= status_c;
            out_hit_reg     <= hit_c;
            out_found_reg   <= found_next;
            out_matched_reg <= matched_next;
            out_plen_reg    <= plen_next;
            out_cnt_reg     <= cnt_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = DATA_W'({out_cnt_reg, out_plen_reg, out_matched_reg,
                              out_found_reg, out_hit_reg, out_status_reg});

endmodule

`default_nettype wire

/* rtl/core/kmp_stream_matcher_unit.sv */
// Each request is taken in ST_IDLE and decoded in ST_DISPATCH. A clear, restart,
// full append, first pattern byte or text byte on an empty pattern then goes to ST_FINISH;
// any other append or text byte first walks the failure chain in ST_SCAN (after a full
// match through ST_FAIL_READ). One request in work; the next is accepted once the result
// is registered, which ST_FINISH does only while the output register is free.
// Reset (aresetn low, synchronous) empties the pattern and clears all search state.
`default_nettype none

module kmp_stream_matcher_unit
    import kmp_sm_pkg::*;
#(
    parameter  int MAX_PATTERN = 32,
    localparam int CW          = $clog2(MAX_PATTERN + 1),
    localparam int DATA_W      = ((4 + 2 * CW + TEXT_POS_W + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output      logic              s_axis_tready,
    // data_byte [7:0]
    input  wire logic [BYTE_W-1:0] s_axis_tdata,
    // req_type [1:0]
    input  wire logic [REQ_W-1:0]  s_axis_tuser,
    output      logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // status [1:0], match_now [2], found_any [3], match_length [4 +: CW],
    // pattern_count [4+CW +: CW], text_position [4+2*CW +: 32], zero fill above
    output      logic [DATA_W-1:0] m_axis_tdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kmp_sm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .stat   (stat),
        .cmd    (cmd)
    );

    kmp_sm_datapath #(
        .MAX_PATTERN(MAX_PATTERN),
        .CW         (CW),
        .DATA_W     (DATA_W)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_type (s_axis_tuser),
        .data_byte(s_axis_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_ready  (m_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* rtl/core/kmp_sm_checker.sv */
// Port-level checker of the KMP stream matcher, bound to the top level.
// Uses kmp_sm_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module kmp_sm_checker
    import kmp_sm_pkg::*;
#(
    parameter int MAX_PATTERN = 32,
    parameter int CW          = $clog2(MAX_PATTERN + 1),
    parameter int DATA_W      = ((4 + 2 * CW + TEXT_POS_W + 7) / 8) * 8
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [DATA_W-1:0] m_axis_tdata
);

    logic [STATUS_W-1:0] status;
    logic                match_now;
    logic                found_any;
    logic [CW-1:0]       match_length;
    logic [CW-1:0]       pattern_count;

    assign status        = m_axis_tdata[STATUS_W-1:0];
    assign match_now     = m_axis_tdata[2];
    assign found_any     = m_axis_tdata[3];
    assign match_length  = m_axis_tdata[4 +: CW];
    assign pattern_count = m_axis_tdata[4 + CW +: CW];

    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "Result dropped or changed while stalled")

    `ASSERT_CLK(a_one_in_work, aclk, aresetn,
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
        "New request taken while the previous one is in work")

    `ASSERT_IMPLY(a_match_full, aclk, aresetn, m_axis_tvalid && match_now,
        found_any && (match_length == pattern_count) && (status == STAT_OK),
        "Match reported without a full-length match")

    `ASSERT_IMPLY(a_len_bound, aclk, aresetn, m_axis_tvalid,
        (match_length <= pattern_count) && (pattern_count <= CW'(MAX_PATTERN)),
        "Match length or pattern count out of range")

endmodule

bind kmp_stream_matcher_unit kmp_sm_checker #(
    .MAX_PATTERN(MAX_PATTERN)
) u_kmp_sm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
